[sv/bbsf_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO package
// Widths, action codes and defaults shared by the stream FIFO files.
// ----------------------------------------------------------------------------
`default_nettype none

package bbsf_pkg;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned TOT_W  = 48;

  localparam int unsigned STORE_DEPTH_DEF = 4096;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4096);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLOSE = 2'd2
  } action_e;

endpackage

`default_nettype wire

[sv/bbsf_in_if.sv]
// ----------------------------------------------------------------------------
// Stream FIFO command channel
// Valid/ready channel that carries one push, pop or close command.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbsf_in_if
  import bbsf_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] data_byte;
  logic [CNT_W-1:0]  pop_length;

  modport source (output valid, output action, output data_byte, output pop_length,
                  input ready);
  modport sink   (input valid, input action, input data_byte, input pop_length,
                  output ready);

endinterface

`default_nettype wire

[sv/bbsf_out_if.sv]
// ----------------------------------------------------------------------------
// Stream FIFO status channel
// Valid/ready channel that carries the stream status after each command.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbsf_out_if
  import bbsf_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] head_byte;
  logic              head_valid;
  logic [CNT_W-1:0]  buffered_count;
  logic [CNT_W-1:0]  free_space;
  logic [TOT_W-1:0]  pushed_total;
  logic [TOT_W-1:0]  popped_total;
  logic              closed_flag;
  logic              finished_flag;
  logic              overflow_error;

  modport source (output valid, output head_byte, output head_valid,
                  output buffered_count, output free_space, output pushed_total,
                  output popped_total, output closed_flag, output finished_flag,
                  output overflow_error, input ready);
  modport sink   (input valid, input head_byte, input head_valid,
                  input buffered_count, input free_space, input pushed_total,
                  input popped_total, input closed_flag, input finished_flag,
                  input overflow_error, output ready);

endinterface

`default_nettype wire

[sv/bounded_byte_stream_fifo_top.sv]
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO
// Byte FIFO with a configurable capacity, close flag and running totals.
// ----------------------------------------------------------------------------
// The command channel in_i carries one push, pop or close per transfer. Every
// command yields exactly one status transfer on out_o with the head byte, the
// fill level, the free space, both 48-bit totals and the closed, finished and
// overflow flags as they stand after the command.
// The bytes live in one synchronous single-write memory. A command updates the
// pointers and counters, writes a pushed byte and reads the new head entry in
// the cycle it is accepted; a push into an empty stream forwards the byte.
// A command is registered first in the command stage and then in the status
// register, which drives out_o, so the status is never combinational from in_i.
// The block takes one command per cycle as long as out_o is ready; the
// command stage and the status register form a two-entry pipeline.
// When out_o stalls, the status register holds and the command stage fills,
// after which in_i.ready drops until a status transfer frees a slot.
// Reset empties the stream, clears totals and flags and sets the capacity to
// 4096. The memory is not cleared; entries are read only after being written.
// cfg_we_i writes the capacity and must only be used while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_byte_stream_fifo_top
  import bbsf_pkg::*;
#(
  parameter int unsigned StoreDepth = STORE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_data_i,
  bbsf_in_if.sink               in_i,
  bbsf_out_if.source            out_o
);

  localparam int unsigned AW     = $clog2(StoreDepth);
  localparam int unsigned SW     = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int unsigned CntMax = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CapMax =
    CNT_W'((StoreDepth > CntMax) ? CntMax : StoreDepth);

  logic [BYTE_W-1:0] byte_store [StoreDepth];
  logic [BYTE_W-1:0] rdata_q;

  logic [CNT_W-1:0] cap_q;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [TOT_W-1:0] tin_q, tin_d;
  logic [TOT_W-1:0] tout_q, tout_d;
  logic             shut_q, shut_d;
  logic             err_q, err_d;

  logic             p_valid_q;
  logic             p_fwd_q;
  logic [BYTE_W-1:0] p_byte_q;
  logic [CNT_W-1:0] p_fill_q;
  logic [TOT_W-1:0] p_tin_q;
  logic [TOT_W-1:0] p_tout_q;
  logic             p_shut_q;
  logic             p_err_q;

  logic              o_valid_q;
  logic [BYTE_W-1:0] o_head_q;
  logic              o_hvalid_q;
  logic [CNT_W-1:0]  o_fill_q;
  logic [CNT_W-1:0]  o_free_q;
  logic [TOT_W-1:0]  o_tin_q;
  logic [TOT_W-1:0]  o_tout_q;
  logic              o_shut_q;
  logic              o_fin_q;
  logic              o_err_q;

  logic             accept;
  logic             move;
  logic             push_ok;
  logic             is_push;
  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] pop_n;
  logic [SW-1:0]    rsum;
  logic [CNT_W-1:0] free_val;

  assign move     = p_valid_q && (!o_valid_q || out_o.ready);
  assign in_i.ready = !p_valid_q || move;
  assign accept   = in_i.valid && in_i.ready;

  assign eff_cap = (cap_q > CapMax) ? CapMax : cap_q;
  assign is_push = (in_i.action == ACT_PUSH);
  assign push_ok = accept && is_push && (fill_q < eff_cap);
  assign pop_n   = (in_i.pop_length < fill_q) ? in_i.pop_length : fill_q;
  assign rsum    = SW'(rptr_q) + SW'(pop_n);

  always_comb begin
    rptr_d = rptr_q;
    wptr_d = wptr_q;
    fill_d = fill_q;
    tin_d  = tin_q;
    tout_d = tout_q;
    shut_d = shut_q;
    err_d  = err_q;
    if (accept) begin
      unique case (in_i.action)
        ACT_PUSH: begin
          if (push_ok) begin
            wptr_d = (wptr_q == AW'(StoreDepth - 1)) ? '0 : wptr_q + 1'b1;
            fill_d = fill_q + 1'b1;
            tin_d  = tin_q + 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        ACT_POP: begin
          rptr_d = (rsum >= SW'(StoreDepth)) ? AW'(rsum - SW'(StoreDepth)) : AW'(rsum);
          fill_d = fill_q - pop_n;
          tout_d = tout_q + TOT_W'(pop_n);
        end
        ACT_CLOSE: begin
          shut_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      byte_store[wptr_q] <= in_i.data_byte;
    end
    if (accept) begin
      rdata_q <= byte_store[rptr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      rptr_q <= '0;
      wptr_q <= '0;
      fill_q <= '0;
      tin_q  <= '0;
      tout_q <= '0;
      shut_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      fill_q <= fill_d;
      tin_q  <= tin_d;
      tout_q <= tout_d;
      shut_q <= shut_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (accept) begin
      p_valid_q <= 1'b1;
    end else if (move) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_fwd_q  <= push_ok && (fill_q == '0) && is_push;
      p_byte_q <= in_i.data_byte;
      p_fill_q <= fill_d;
      p_tin_q  <= tin_d;
      p_tout_q <= tout_d;
      p_shut_q <= shut_d;
      p_err_q  <= err_d;
    end
  end

  assign free_val = (eff_cap > p_fill_q) ? eff_cap - p_fill_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (move) begin
      o_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      if (p_fill_q == '0) begin
        o_head_q <= '0;
      end else if (p_fwd_q) begin
        o_head_q <= p_byte_q;
      end else begin
        o_head_q <= rdata_q;
      end
      o_hvalid_q <= (p_fill_q != '0);
      o_fill_q   <= p_fill_q;
      o_free_q   <= free_val;
      o_tin_q    <= p_tin_q;
      o_tout_q   <= p_tout_q;
      o_shut_q   <= p_shut_q;
      o_fin_q    <= p_shut_q && (p_tin_q == p_tout_q);
      o_err_q    <= p_err_q;
    end
  end

  assign out_o.valid          = o_valid_q;
  assign out_o.head_byte      = o_head_q;
  assign out_o.head_valid     = o_hvalid_q;
  assign out_o.buffered_count = o_fill_q;
  assign out_o.free_space     = o_free_q;
  assign out_o.pushed_total   = o_tin_q;
  assign out_o.popped_total   = o_tout_q;
  assign out_o.closed_flag    = o_shut_q;
  assign out_o.finished_flag  = o_fin_q;
  assign out_o.overflow_error = o_err_q;

endmodule

`default_nettype wire

[sv/bbsf_checker.sv]
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO checker
// Port-level assertions on the status channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bbsf_checker
  import bbsf_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [BYTE_W-1:0] head_byte_i,
  input wire logic              head_valid_i,
  input wire logic [CNT_W-1:0]  buffered_count_i,
  input wire logic              closed_flag_i,
  input wire logic              finished_flag_i,
  input wire logic              overflow_error_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("Status was withdrawn before its transfer.");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (head_valid_i == (buffered_count_i != '0)))
    else $error("Head valid disagrees with the fill level.");

  a_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !head_valid_i) |-> (head_byte_i == '0))
    else $error("Head byte is not zero on an empty stream.");

  a_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && finished_flag_i) |-> (closed_flag_i && !head_valid_i))
    else $error("Finished reported on an open or non-empty stream.");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && overflow_error_i) |=>
      (!out_valid_i || overflow_error_i))
    else $error("Overflow error cleared without reset.");

endmodule

bind bounded_byte_stream_fifo_top bbsf_checker u_bbsf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .head_byte_i      (out_o.head_byte),
  .head_valid_i     (out_o.head_valid),
  .buffered_count_i (out_o.buffered_count),
  .closed_flag_i    (out_o.closed_flag),
  .finished_flag_i  (out_o.finished_flag),
  .overflow_error_i (out_o.overflow_error)
);

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO testbench
// Drives push, pop, close and spare commands through the command channel and
// checks every status transfer field by field against a behavioral model of
// the stream. A directed script covers empty pops, over-long pops, capacity
// one, zero and beyond the store depth, overflow and close. A long run of
// pushes then stalls the command side while the status side holds off. Random
// phases follow at several capacities, with random gaps on both channels but in the last.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bbsf_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned FILL_ITEMS = 150;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned NUM_PHASES = 9;
  localparam int unsigned SCRIPT_ROWS = 24;
  localparam int unsigned PTR_W = $clog2(STORE_DEPTH_DEF);

  typedef struct {
    logic [BYTE_W-1:0] head_byte;
    logic              head_valid;
    logic [CNT_W-1:0]  buffered_count;
    logic [CNT_W-1:0]  free_space;
    logic [TOT_W-1:0]  pushed_total;
    logic [TOT_W-1:0]  popped_total;
    logic              closed_flag;
    logic              finished_flag;
    logic              overflow_error;
  } status_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CNT_W-1:0]  cap_val;
    logic [ACT_W-1:0]  act;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  plen;
    logic              pin;
    logic [BYTE_W-1:0] pin_head;
    logic [CNT_W-1:0]  pin_count;
    logic              pin_err;
  } step_row_t;

  localparam step_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{1'b0, 13'd0,    ACT_POP,   8'h00, 13'd0,    1'b1, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_POP,   8'h00, 13'd8191, 1'b1, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_SPARE, 8'hFF, 13'd8191, 1'b1, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_PUSH,  8'hFF, 13'd0,    1'b1, 8'hFF, 13'd1, 1'b0},
    '{1'b0, 13'd0,    ACT_PUSH,  8'h00, 13'd8191, 1'b1, 8'hFF, 13'd2, 1'b0},
    '{1'b0, 13'd0,    ACT_PUSH,  8'hA5, 13'd0,    1'b0, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_POP,   8'hFF, 13'd1,    1'b1, 8'h00, 13'd2, 1'b0},
    '{1'b0, 13'd0,    ACT_POP,   8'h00, 13'd4096, 1'b1, 8'h00, 13'd0, 1'b0},
    '{1'b1, 13'd1,    ACT_PUSH,  8'h00, 13'd0,    1'b0, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_PUSH,  8'h3C, 13'd0,    1'b1, 8'h3C, 13'd1, 1'b0},
    '{1'b0, 13'd0,    ACT_PUSH,  8'hC3, 13'd0,    1'b1, 8'h3C, 13'd1, 1'b1},
    '{1'b1, 13'd0,    ACT_PUSH,  8'h00, 13'd0,    1'b0, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_PUSH,  8'h77, 13'd0,    1'b1, 8'h3C, 13'd1, 1'b1},
    '{1'b0, 13'd0,    ACT_POP,   8'h00, 13'd1,    1'b1, 8'h00, 13'd0, 1'b1},
    '{1'b0, 13'd0,    ACT_PUSH,  8'h55, 13'd0,    1'b1, 8'h00, 13'd0, 1'b1},
    '{1'b1, 13'd8191, ACT_PUSH,  8'h00, 13'd0,    1'b0, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_PUSH,  8'h80, 13'd0,    1'b1, 8'h80, 13'd1, 1'b1},
    '{1'b0, 13'd0,    ACT_PUSH,  8'h01, 13'd0,    1'b0, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_POP,   8'h00, 13'd2,    1'b1, 8'h00, 13'd0, 1'b1},
    '{1'b0, 13'd0,    ACT_CLOSE, 8'h00, 13'd0,    1'b0, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_CLOSE, 8'hFF, 13'd8191, 1'b0, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_PUSH,  8'h7F, 13'd0,    1'b1, 8'h7F, 13'd1, 1'b1},
    '{1'b0, 13'd0,    ACT_SPARE, 8'h00, 13'd0,    1'b0, 8'h00, 13'd0, 1'b0},
    '{1'b0, 13'd0,    ACT_POP,   8'h00, 13'd8191, 1'b1, 8'h00, 13'd0, 1'b1}
  };

  localparam logic [CNT_W-1:0] PHASE_CAPS [NUM_PHASES] = '{
    13'd4096, 13'd5, 13'd0, 13'd1, 13'd2, 13'd40, 13'd8191, 13'd3, 13'd4096
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  bbsf_in_if  cmd_ch ();
  bbsf_out_if stat_ch ();

  bounded_byte_stream_fifo_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_ch),
    .out_o      (stat_ch)
  );

  logic [BYTE_W-1:0] mirror_mem [STORE_DEPTH_DEF];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  int unsigned       fill_level;
  logic [TOT_W-1:0]  in_total;
  logic [TOT_W-1:0]  out_total;
  logic              shut;
  logic              dropped;
  logic [CNT_W-1:0]  cap_reg;

  status_t     pending_status [$];
  int unsigned mismatch_count;
  bit          idle_en;
  bit          hold_req;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [TOT_W-1:0] got,
                                 input logic [TOT_W-1:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  function automatic status_t advance_stream(input logic [ACT_W-1:0] act,
                                             input logic [BYTE_W-1:0] data,
                                             input logic [CNT_W-1:0] plen);
    int unsigned room;
    int unsigned n;
    status_t     s;
    room = (32'(cap_reg) > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : 32'(cap_reg);
    case (act)
      ACT_PUSH: begin
        if (fill_level >= room) begin
          dropped = 1'b1;
        end else begin
          mirror_mem[wr_ptr] = data;
          wr_ptr = wr_ptr + 1'b1;
          fill_level++;
          in_total = in_total + 1'b1;
        end
      end
      ACT_POP: begin
        n = (32'(plen) < fill_level) ? 32'(plen) : fill_level;
        rd_ptr = PTR_W'(32'(rd_ptr) + n);
        fill_level -= n;
        out_total = out_total + TOT_W'(n);
      end
      ACT_CLOSE: shut = 1'b1;
      default: ;
    endcase
    s.head_valid     = (fill_level != 0);
    s.head_byte      = s.head_valid ? mirror_mem[rd_ptr] : '0;
    s.buffered_count = CNT_W'(fill_level);
    s.free_space     = (room > fill_level) ? CNT_W'(room - fill_level) : '0;
    s.pushed_total   = in_total;
    s.popped_total   = out_total;
    s.closed_flag    = shut;
    s.finished_flag  = shut && (in_total == out_total);
    s.overflow_error = dropped;
    return s;
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] data,
                           input logic [CNT_W-1:0] plen, input logic pin = 1'b0,
                           input logic [BYTE_W-1:0] pin_head = '0,
                           input logic [CNT_W-1:0] pin_count = '0,
                           input logic pin_err = 1'b0);
    status_t want;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.action     <= act;
    cmd_ch.data_byte  <= data;
    cmd_ch.pop_length <= plen;
    do @(posedge clk_i); while (!cmd_ch.ready);
    want = advance_stream(act, data, plen);
    if (pin) begin
      want.head_byte      = pin_head;
      want.head_valid     = (pin_count != 0);
      want.buffered_count = pin_count;
      want.overflow_error = pin_err;
    end
    pending_status.push_back(want);
  endtask

  task automatic send_random_item();
    int unsigned      pick;
    logic [ACT_W-1:0] act;
    logic [CNT_W-1:0] plen;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      act = ACT_PUSH;
    end else if (pick < 90) begin
      act = ACT_POP;
    end else if (pick < 94) begin
      act = ACT_CLOSE;
    end else begin
      act = ACT_SPARE;
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      plen = CNT_W'($urandom_range(0, 4));
    end else if (pick < 95) begin
      plen = CNT_W'($urandom_range(0, fill_level + 2));
    end else begin
      plen = CNT_W'($urandom_range(0, 8191));
    end
    send_item(act, BYTE_W'($urandom_range(0, 255)), plen);
  endtask

  task automatic drain_stream();
    cmd_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] val);
    drain_stream();
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    cap_reg = val;
  endtask

  initial begin : status_ready_drive
    stat_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stat_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        stat_ch.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stat_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        stat_ch.ready <= 1'b1;
      end else begin
        stat_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : status_check
    status_t want;
    if (rst_ni && stat_ch.valid && stat_ch.ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected status transfer", '0, '0);
      end else begin
        want = pending_status.pop_front();
        if (stat_ch.head_byte !== want.head_byte)
          report_mismatch("head_byte", TOT_W'(stat_ch.head_byte),
                          TOT_W'(want.head_byte));
        if (stat_ch.head_valid !== want.head_valid)
          report_mismatch("head_valid", TOT_W'(stat_ch.head_valid),
                          TOT_W'(want.head_valid));
        if (stat_ch.buffered_count !== want.buffered_count)
          report_mismatch("buffered_count", TOT_W'(stat_ch.buffered_count),
                          TOT_W'(want.buffered_count));
        if (stat_ch.free_space !== want.free_space)
          report_mismatch("free_space", TOT_W'(stat_ch.free_space),
                          TOT_W'(want.free_space));
        if (stat_ch.pushed_total !== want.pushed_total)
          report_mismatch("pushed_total", stat_ch.pushed_total, want.pushed_total);
        if (stat_ch.popped_total !== want.popped_total)
          report_mismatch("popped_total", stat_ch.popped_total, want.popped_total);
        if (stat_ch.closed_flag !== want.closed_flag)
          report_mismatch("closed_flag", TOT_W'(stat_ch.closed_flag),
                          TOT_W'(want.closed_flag));
        if (stat_ch.finished_flag !== want.finished_flag)
          report_mismatch("finished_flag", TOT_W'(stat_ch.finished_flag),
                          TOT_W'(want.finished_flag));
        if (stat_ch.overflow_error !== want.overflow_error)
          report_mismatch("overflow_error", TOT_W'(stat_ch.overflow_error),
                          TOT_W'(want.overflow_error));
      end
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] cap;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_data          <= '0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.action     <= ACT_PUSH;
    cmd_ch.data_byte  <= '0;
    cmd_ch.pop_length <= '0;
    rd_ptr         = '0;
    wr_ptr         = '0;
    fill_level     = 0;
    in_total       = '0;
    out_total      = '0;
    shut           = 1'b0;
    dropped        = 1'b0;
    cap_reg        = CAP_RESET;
    mismatch_count = 0;
    idle_en        = 1'b1;
    hold_req       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (SCRIPT[i].is_cfg) begin
        write_capacity(SCRIPT[i].cap_val);
      end else begin
        send_item(SCRIPT[i].act, SCRIPT[i].data, SCRIPT[i].plen, SCRIPT[i].pin,
                  SCRIPT[i].pin_head, SCRIPT[i].pin_count, SCRIPT[i].pin_err);
      end
    end

    // Keep pushing while the status side holds off so the command side stalls.
    write_capacity(13'd8191);
    hold_req = 1'b1;
    repeat (FILL_ITEMS) begin
      send_item(ACT_PUSH, BYTE_W'($urandom_range(0, 255)), CNT_W'($urandom_range(0, 8191)));
    end
    while (fill_level != 0) begin
      send_item(ACT_POP, BYTE_W'($urandom_range(0, 255)), CNT_W'($urandom_range(1, 400)));
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cap = (ph == 5) ? CNT_W'($urandom_range(1, 4096)) : PHASE_CAPS[ph];
      write_capacity(cap);
      if (ph == NUM_PHASES - 1) idle_en = 1'b0;
      repeat (PHASE_ITEMS) send_random_item();
      repeat ($urandom_range(0, 24)) begin
        send_item(ACT_PUSH, BYTE_W'($urandom_range(0, 255)), CNT_W'($urandom_range(0, 8191)));
      end
    end

    drain_stream();
    repeat (20) @(posedge clk_i);
    if (pending_status.size() != 0) begin
      report_mismatch("status transfers missing", TOT_W'(pending_status.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
